[rtl/clib_pkg.sv]
// Shared types and constants for the cooked line input buffer.
// No dependencies; every other file but clib_ram refers to this package by scoped names.
package clib_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int CNT_W      = 7;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CTRL_BIT = 8'h40;

    localparam logic [CNT_W-1:0] MAX_READ = 7'd64;

    typedef enum logic [1:0] {
        RK_ECHO = 2'd0,
        RK_DATA = 2'd1,
        RK_NONE = 2'd2
    } t_rkind;

    typedef enum logic [1:0] {
        CLS_ERASE,
        CLS_NL,
        CLS_CTRL,
        CLS_PLAIN
    } t_cls;

    typedef struct packed {
        logic             is_read;
        t_cls             cls;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERASE_CHK,
        S_ECHO,
        S_READ
    } t_state;

endpackage

[rtl/clib_front.sv]
// Front end: accepts input items and classifies them into commands.
// Depends on clib_pkg; feeds clib_queue.
module clib_front (
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic [7:0]                i_data_byte,
    input  logic [clib_pkg::CNT_W-1:0] i_read_count,
    input  logic                      i_full,
    output logic                      o_push,
    output clib_pkg::t_cmd            o_cmd
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd         = '0;
        o_cmd.is_read = i_kind;
        o_cmd.data    = i_data_byte;
        o_cmd.count   = (i_read_count > clib_pkg::MAX_READ) ? clib_pkg::MAX_READ
                                                            : i_read_count;
        // CR is stored as LF, so both fall into the newline class.
        priority if (i_data_byte == clib_pkg::CH_BS || i_data_byte == clib_pkg::CH_DEL) begin
            o_cmd.cls = clib_pkg::CLS_ERASE;
        end else if (i_data_byte == clib_pkg::CH_LF || i_data_byte == clib_pkg::CH_CR) begin
            o_cmd.cls  = clib_pkg::CLS_NL;
            o_cmd.data = clib_pkg::CH_LF;
        end else if (i_data_byte < clib_pkg::CH_SPACE) begin
            o_cmd.cls = clib_pkg::CLS_CTRL;
        end else begin
            o_cmd.cls = clib_pkg::CLS_PLAIN;
        end
    end

endmodule

[rtl/clib_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on clib_pkg for the command type.
module clib_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clib_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output clib_pkg::t_cmd o_cmd
);

    clib_pkg::t_cmd r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_full      = (r_cnt == 2'd2);
    assign o_not_empty = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/clib_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/clib_back.sv]
// Back end: owns the line store, pointers and line count, executes commands
// and drives the result register. Depends on clib_pkg and clib_ram.
module clib_back #(
    parameter int LINE_DEPTH = clib_pkg::LINE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  clib_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_result_kind,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);

    localparam int PW = $clog2(LINE_DEPTH);

    clib_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW:0]      r_lines, n_lines;
    logic [7:0]       r_buf [3];
    logic [7:0]       n_buf [3];
    clib_pkg::t_rkind r_ekind, n_ekind;
    logic [1:0]       r_elen, n_elen;
    logic [1:0]       r_eidx, n_eidx;
    logic [clib_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic             r_ov, n_ov;
    clib_pkg::t_rkind r_okind, n_okind;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_olast, n_olast;

    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    logic             ram_re;
    logic [PW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    logic             load_ok;
    logic [PW-1:0]    left;
    logic [PW-1:0]    rp_inc;
    logic [PW-1:0]    wp_dec;
    logic             rd_last;

    assign o_valid       = r_ov;
    assign o_result_kind = r_okind;
    assign o_out_byte    = r_obyte;
    assign o_last        = r_olast;

    assign load_ok = !r_ov || !i_stall;
    assign rp_inc  = r_rp + PW'(1);
    assign wp_dec  = r_wp - PW'(1);
    // Free space as the ring counts it: one slot is always kept empty.
    assign left    = (r_rp <= r_wp) ? PW'(r_rp - r_wp - PW'(1)) : PW'(r_rp - r_wp);
    assign rd_last = (ram_rdata == clib_pkg::CH_LF) || (rp_inc == r_wp)
                     || (r_cnt == clib_pkg::CNT_W'(1));

    clib_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_lines   = r_lines;
        n_buf     = r_buf;
        n_ekind   = r_ekind;
        n_elen    = r_elen;
        n_eidx    = r_eidx;
        n_cnt     = r_cnt;
        n_ov      = r_ov && i_stall;
        n_okind   = r_okind;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_re    = 1'b0;
        ram_raddr = r_rp;

        unique case (r_state)
            clib_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_eidx  = 2'd0;
                    n_ekind = clib_pkg::RK_ECHO;
                    if (i_cmd.is_read) begin
                        if (r_lines == '0 || r_rp == r_wp) begin
                            n_ekind  = clib_pkg::RK_NONE;
                            n_buf[0] = 8'h00;
                            n_elen   = 2'd1;
                            n_state  = clib_pkg::S_ECHO;
                        end else if (i_cmd.count != '0) begin
                            ram_re    = 1'b1;
                            ram_raddr = r_rp;
                            n_cnt     = i_cmd.count;
                            n_state   = clib_pkg::S_READ;
                        end
                    end else if (i_cmd.cls == clib_pkg::CLS_ERASE) begin
                        if (r_rp != r_wp) begin
                            ram_re    = 1'b1;
                            ram_raddr = wp_dec;
                            n_state   = clib_pkg::S_ERASE_CHK;
                        end
                    end else if (!(left <= PW'(1) ||
                                   (left <= PW'(2) && i_cmd.cls != clib_pkg::CLS_NL))) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wp;
                        n_wp      = r_wp + PW'(1);
                        n_state   = clib_pkg::S_ECHO;
                        unique case (i_cmd.cls)
                            clib_pkg::CLS_NL: begin
                                n_lines  = r_lines + (PW+1)'(1);
                                n_buf[0] = clib_pkg::CH_CR;
                                n_buf[1] = clib_pkg::CH_LF;
                                n_elen   = 2'd2;
                            end
                            clib_pkg::CLS_CTRL: begin
                                n_buf[0] = clib_pkg::CH_CARET;
                                n_buf[1] = i_cmd.data | clib_pkg::CTRL_BIT;
                                n_elen   = 2'd2;
                            end
                            default: begin
                                n_buf[0] = i_cmd.data;
                                n_elen   = 2'd1;
                            end
                        endcase
                    end
                end
            end
            clib_pkg::S_ERASE_CHK: begin
                // A stored LF closes a line and is never erased.
                if (ram_rdata == clib_pkg::CH_LF) begin
                    n_state = clib_pkg::S_IDLE;
                end else begin
                    n_wp     = wp_dec;
                    n_buf[0] = clib_pkg::CH_BS;
                    n_buf[1] = clib_pkg::CH_SPACE;
                    n_buf[2] = clib_pkg::CH_BS;
                    n_elen   = 2'd3;
                    n_state  = clib_pkg::S_ECHO;
                end
            end
            clib_pkg::S_ECHO: begin
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_okind = r_ekind;
                    n_obyte = r_buf[r_eidx];
                    n_olast = (r_eidx == r_elen - 2'd1);
                    if (r_eidx == r_elen - 2'd1) begin
                        n_state = clib_pkg::S_IDLE;
                    end else begin
                        n_eidx = r_eidx + 2'd1;
                    end
                end
            end
            clib_pkg::S_READ: begin
                // Read data stays in the RAM output register until the next read.
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_okind = clib_pkg::RK_DATA;
                    n_obyte = ram_rdata;
                    n_olast = rd_last;
                    n_rp    = rp_inc;
                    if (ram_rdata == clib_pkg::CH_LF) begin
                        n_lines = r_lines - (PW+1)'(1);
                    end
                    if (rd_last) begin
                        n_state = clib_pkg::S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = rp_inc;
                        n_cnt     = r_cnt - clib_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = clib_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clib_pkg::S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_lines <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_lines <= n_lines;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf   <= n_buf;
        r_ekind <= n_ekind;
        r_elen  <= n_elen;
        r_eidx  <= n_eidx;
        r_cnt   <= n_cnt;
        r_okind <= n_okind;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

endmodule

[rtl/cooked_line_input_buffer_top.sv]
// A received byte is executed by the back end and then echoed one echo byte at a time
// (erase first reads the line store); a read returns its result bytes one at a time.
// The back end runs one command at a time and takes no new command until the last
// result of the current one is loaded; any output stall holds it further.
// A two-entry command queue lets the front end keep accepting while results wait.
// Reset clears pointers, line count and handshake state; the store is not cleared.
module cooked_line_input_buffer_top #(
    parameter int LINE_DEPTH = clib_pkg::LINE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_kind,
    input  logic [7:0]                 i_data_byte,
    input  logic [clib_pkg::CNT_W-1:0] i_read_count,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_result_kind,
    output logic [7:0]                 o_out_byte,
    output logic                       o_last
);

    logic           push;
    logic           full;
    logic           pop;
    logic           not_empty;
    clib_pkg::t_cmd front_cmd;
    clib_pkg::t_cmd head_cmd;

    clib_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_read_count (i_read_count),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    clib_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_cmd       (head_cmd)
    );

    clib_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (not_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for cooked_line_input_buffer_top: line editing, echo,
// erase rules, full-store drops and line reads against an in-bench line editor.
// Depends on rtl/clib_pkg.sv and rtl/cooked_line_input_buffer_top.sv.
module tb_top;

    localparam int PTR_W          = $clog2(clib_pkg::LINE_DEPTH);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        clib_pkg::t_rkind rkind;
        logic [7:0]       ch;
        logic             last;
    } t_char_result;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       i_kind       = 1'b0;
    logic [7:0]                 i_data_byte  = 8'h00;
    logic [clib_pkg::CNT_W-1:0] i_read_count = '0;
    logic                       i_stall      = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [1:0]                 o_result_kind;
    logic [7:0]                 o_out_byte;
    logic                       o_last;

    // Shadow of the line editor state.
    logic [7:0]       shadow_store [clib_pkg::LINE_DEPTH];
    logic [PTR_W-1:0] shadow_rd;
    logic [PTR_W-1:0] shadow_wr;
    logic [8:0]       shadow_lines;

    t_char_result awaited_chars [$];
    int           mismatches;
    int           idle_cycles;
    int           snd_idle_pct;
    int           rcv_stall_pct;
    int           hold_len;
    int           hold_ticket;
    int           hold_seen;
    int           hold_cnt;

    cooked_line_input_buffer_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_read_count (i_read_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result_kind(o_result_kind),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 200) begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic push_char(input clib_pkg::t_rkind rk, input logic [7:0] ch);
        t_char_result r;
        r.rkind = rk;
        r.ch    = ch;
        r.last  = 1'b0;
        awaited_chars.push_back(r);
    endtask

    // Applies one accepted item to the shadow state and queues what it must produce.
    task automatic model_line_edit(input logic kind, input logic [7:0] ch_in,
                                   input logic [clib_pkg::CNT_W-1:0] cnt_in);
        logic [7:0]                 ch;
        logic [PTR_W-1:0]           prev;
        logic [clib_pkg::CNT_W-1:0] cnt;
        int                         left;
        int                         n;
        int                         start;
        t_char_result               tail;
        start = awaited_chars.size();
        ch    = ch_in;
        if (!kind) begin
            if (ch == clib_pkg::CH_BS || ch == clib_pkg::CH_DEL) begin
                prev = shadow_wr - 1'b1;
                // An erase never removes a stored line end.
                if (shadow_rd != shadow_wr && shadow_store[prev] != clib_pkg::CH_LF) begin
                    shadow_wr = prev;
                    push_char(clib_pkg::RK_ECHO, clib_pkg::CH_BS);
                    push_char(clib_pkg::RK_ECHO, clib_pkg::CH_SPACE);
                    push_char(clib_pkg::RK_ECHO, clib_pkg::CH_BS);
                end
            end else begin
                if (shadow_rd <= shadow_wr) begin
                    left = clib_pkg::LINE_DEPTH - int'(shadow_wr) + int'(shadow_rd) - 1;
                end else begin
                    left = int'(shadow_rd) - int'(shadow_wr);
                end
                if (!(left <= 1 || (left <= 2 && ch != clib_pkg::CH_CR &&
                                    ch != clib_pkg::CH_LF))) begin
                    if (ch == clib_pkg::CH_CR) begin
                        ch = clib_pkg::CH_LF;
                    end
                    shadow_store[shadow_wr] = ch;
                    shadow_wr = shadow_wr + 1'b1;
                    if (ch == clib_pkg::CH_LF) begin
                        push_char(clib_pkg::RK_ECHO, clib_pkg::CH_CR);
                        push_char(clib_pkg::RK_ECHO, clib_pkg::CH_LF);
                        shadow_lines = shadow_lines + 1'b1;
                    end else if (ch < clib_pkg::CH_SPACE) begin
                        push_char(clib_pkg::RK_ECHO, clib_pkg::CH_CARET);
                        push_char(clib_pkg::RK_ECHO, ch | clib_pkg::CTRL_BIT);
                    end else begin
                        push_char(clib_pkg::RK_ECHO, ch);
                    end
                end
            end
        end else begin
            if (shadow_lines == 0 || shadow_rd == shadow_wr) begin
                push_char(clib_pkg::RK_NONE, 8'h00);
            end else begin
                cnt = (cnt_in > clib_pkg::MAX_READ) ? clib_pkg::MAX_READ : cnt_in;
                n   = 0;
                while (shadow_lines != 0 && n < int'(cnt)) begin
                    ch = shadow_store[shadow_rd];
                    shadow_rd = shadow_rd + 1'b1;
                    push_char(clib_pkg::RK_DATA, ch);
                    n++;
                    if (ch == clib_pkg::CH_LF) begin
                        shadow_lines = shadow_lines - 1'b1;
                        break;
                    end
                    if (shadow_rd == shadow_wr) begin
                        break;
                    end
                end
            end
        end
        if (awaited_chars.size() > start) begin
            tail = awaited_chars.pop_back();
            tail.last = 1'b1;
            awaited_chars.push_back(tail);
        end
    endtask

    task automatic send_item(input logic kind, input logic [7:0] ch,
                             input logic [clib_pkg::CNT_W-1:0] cnt);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_data_byte  <= ch;
        i_read_count <= cnt;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        model_line_edit(kind, ch, cnt);
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_item(1'b0, ch, 7'($urandom));
    endtask

    task automatic send_read(input logic [clib_pkg::CNT_W-1:0] cnt);
        send_item(1'b1, 8'($urandom), cnt);
    endtask

    function automatic logic [7:0] pick_line_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 10) begin
            c = r[0] ? clib_pkg::CH_BS : clib_pkg::CH_DEL;
        end else if (r < 16) begin
            do c = 8'($urandom_range(31));
            while (c == clib_pkg::CH_BS || c == clib_pkg::CH_LF || c == clib_pkg::CH_CR);
        end else begin
            do c = 8'($urandom); while (c < clib_pkg::CH_SPACE || c == clib_pkg::CH_DEL);
        end
        return c;
    endfunction

    task automatic test_echo_classes();
        send_read(7'd1);            // nothing held yet
        send_byte(clib_pkg::CH_BS); // erase on empty store is ignored
        send_byte(clib_pkg::CH_DEL);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(clib_pkg::CH_SPACE);
        send_byte(8'hFF);
        send_byte(8'h7E);
        send_byte(8'h80);
    endtask

    task automatic test_erase_rules();
        send_byte(clib_pkg::CH_DEL);
        send_byte(clib_pkg::CH_BS);
        send_read(7'd5);            // partial line only
        send_byte(clib_pkg::CH_CR);
        send_byte(clib_pkg::CH_BS); // would remove the line end, refused
        send_byte(8'h78);
        send_byte(clib_pkg::CH_LF);
    endtask

    task automatic test_read_rules();
        send_read(7'd0);
        send_read(7'd2);
        send_read(7'd127);          // clamps to the maximum, stops at line end
        send_read(7'd64);
        send_read(7'd1);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(clib_pkg::CH_LF);
        send_read(7'd2);
        send_read(7'd64);
    endtask

    // Fills the store to its limit, checks the drop thresholds, then drains it.
    task automatic test_store_full();
        logic [7:0] c;
        repeat (clib_pkg::LINE_DEPTH) begin
            do c = 8'($urandom);
            while (c == clib_pkg::CH_BS || c == clib_pkg::CH_DEL ||
                   c == clib_pkg::CH_CR || c == clib_pkg::CH_LF);
            send_byte(c);
        end
        send_byte(clib_pkg::CH_CR);
        send_byte(clib_pkg::CH_LF);
        send_byte(8'h51);
        repeat (5) begin
            send_read(clib_pkg::MAX_READ);
        end
    endtask

    task automatic test_random_lines(input int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                len = $urandom_range(8);
                repeat (len) begin
                    send_byte(pick_line_char());
                    sent++;
                end
                send_byte($urandom_range(1) ? clib_pkg::CH_CR : clib_pkg::CH_LF);
                sent++;
                r = $urandom_range(99);
                if (r < 60) begin
                    send_read(7'($urandom_range(1, 12)));
                    sent++;
                end else if (r < 70) begin
                    send_read(7'($urandom_range(13, 127)));
                    sent++;
                end
            end else begin
                send_item(1'($urandom), 8'($urandom), 7'($urandom));
                sent++;
            end
        end
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_backpressure();
        int k;
        hold_len = HOLD_CYCLES;
        hold_ticket++;
        for (k = 0; k < 20; k++) begin
            send_byte(8'h61 + 8'(k));
        end
        send_byte(clib_pkg::CH_CR);
        send_read(clib_pkg::MAX_READ);
    endtask

    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_cnt  = hold_len;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_char_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                          o_result_kind, o_out_byte, o_last));
            end else begin
                want = awaited_chars.pop_front();
                if (o_result_kind !== want.rkind || o_out_byte !== want.ch ||
                    o_last !== want.last) begin
                    report_mismatch($sformatf(
                        "kind %0d/%0d byte %02h/%02h last %0b/%0b (got/want)",
                        o_result_kind, want.rkind, o_out_byte, want.ch, o_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        hold_len      = 0;
        hold_ticket   = 0;
        hold_seen     = 0;
        hold_cnt      = 0;
        shadow_rd     = '0;
        shadow_wr     = '0;
        shadow_lines  = '0;
        snd_idle_pct  = 34;
        rcv_stall_pct = 64;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_echo_classes();
        test_erase_rules();
        test_read_rules();
        test_store_full();
        test_random_lines(16);

        snd_idle_pct  = 64;
        rcv_stall_pct = 34;
        test_random_lines(16);

        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_backpressure();
        test_random_lines(16);

        i_valid <= 1'b0;
        while (awaited_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_chars.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
